// ----- design/slw_pkg.sv -----
// ----------------------------------------------------------------------------
// slw_pkg
// Shared types and constants of the SPI LCD window pixel writer: item
// actions, command opcodes and field widths.
// ----------------------------------------------------------------------------
package slw_pkg;

    localparam int BYTE_W  = 8;
    localparam int PIXEL_W = 16;
    localparam int COORD_W = 16;

    typedef enum logic [1:0] {
        ACT_SET_DC     = 2'd0,
        ACT_SPI_BYTE   = 2'd1,
        ACT_READ_PIXEL = 2'd2,
        ACT_FLUSH_DONE = 2'd3
    } action_t;

    localparam logic [BYTE_W-1:0] OP_COLUMN_SET   = 8'h2A;
    localparam logic [BYTE_W-1:0] OP_ROW_SET      = 8'h2B;
    localparam logic [BYTE_W-1:0] OP_MEMORY_WRITE = 8'h2C;

endpackage

// ----- design/slw_ctrl.sv -----
// ----------------------------------------------------------------------------
// slw_ctrl
// Command decoder and window state: D/C pin, opcode, window parameters,
// pixel byte pairing, write cursor and dirty flag.
// ----------------------------------------------------------------------------
module slw_ctrl #(
    parameter int WIDTH = 240,
    parameter int HEIGHT = 320,
    localparam int PIXEL_COUNT = WIDTH * HEIGHT,
    localparam int ADDR_W = (PIXEL_COUNT > 1) ? $clog2(PIXEL_COUNT) : 1
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   fire,
    input  slw_pkg::action_t       action,
    input  logic                   dc_level,
    input  logic [7:0]             spi_byte,
    output logic                   wr_en,
    output logic [ADDR_W-1:0]      wr_addr,
    output logic [15:0]            wr_data,
    output logic                   dirty_out
);
    import slw_pkg::*;

    localparam logic [COORD_W-1:0] COL_MAX = COORD_W'(WIDTH - 1);
    localparam logic [COORD_W-1:0] ROW_MAX = COORD_W'(HEIGHT - 1);

    logic                data_mode_reg, data_mode_next;
    logic [BYTE_W-1:0]   opcode_reg, opcode_next;
    logic [2:0]          param_count_reg, param_count_next;
    logic [BYTE_W-1:0]   param_bytes_reg [3];
    logic [BYTE_W-1:0]   param_bytes_next [3];
    logic                expect_high_reg, expect_high_next;
    logic [BYTE_W-1:0]   high_byte_reg, high_byte_next;
    logic [COORD_W-1:0]  col_first_reg, col_first_next;
    logic [COORD_W-1:0]  col_last_reg, col_last_next;
    logic [COORD_W-1:0]  row_first_reg, row_first_next;
    logic [COORD_W-1:0]  row_last_reg, row_last_next;
    logic [COORD_W-1:0]  cursor_col_reg, cursor_col_next;
    logic [COORD_W-1:0]  cursor_row_reg, cursor_row_next;
    logic                changed_reg, changed_next;

    logic [COORD_W-1:0]  win_first;
    logic [COORD_W-1:0]  win_last;
    logic [COORD_W-1:0]  col_inc;
    logic [COORD_W-1:0]  row_inc;
    logic                in_panel;
    logic [31:0]         lin_addr;

    assign win_first = {param_bytes_reg[0], param_bytes_reg[1]};
    assign win_last  = {param_bytes_reg[2], spi_byte};
    assign col_inc   = cursor_col_reg + 16'd1;
    assign row_inc   = cursor_row_reg + 16'd1;
    assign in_panel  = (32'(cursor_row_reg) < 32'(HEIGHT)) && (32'(cursor_col_reg) < 32'(WIDTH));
    assign lin_addr  = 32'(cursor_row_reg) * 32'(WIDTH) + 32'(cursor_col_reg);
    assign wr_addr   = lin_addr[ADDR_W-1:0];
    assign wr_data   = {high_byte_reg, spi_byte};

    always_comb
    begin
        data_mode_next   = data_mode_reg;
        opcode_next      = opcode_reg;
        param_count_next = param_count_reg;
        param_bytes_next = param_bytes_reg;
        expect_high_next = expect_high_reg;
        high_byte_next   = high_byte_reg;
        col_first_next   = col_first_reg;
        col_last_next    = col_last_reg;
        row_first_next   = row_first_reg;
        row_last_next    = row_last_reg;
        cursor_col_next  = cursor_col_reg;
        cursor_row_next  = cursor_row_reg;
        changed_next     = changed_reg;
        wr_en            = 1'b0;

        if (fire)
        begin
            case (action)
                ACT_SET_DC:
                begin
                    data_mode_next = dc_level;
                    if (!dc_level)
                    begin
                        param_count_next = 3'd0;
                        expect_high_next = 1'b1;
                    end
                end
                ACT_SPI_BYTE:
                begin
                    if (!data_mode_reg)
                    begin
                        opcode_next      = spi_byte;
                        param_count_next = 3'd0;
                        expect_high_next = 1'b1;
                    end
                    else
                    begin
                        unique case (opcode_reg) inside
                            OP_COLUMN_SET, OP_ROW_SET:
                            begin
                                if (param_count_reg < 3'd3)
                                begin
                                    param_bytes_next[param_count_reg[1:0]] = spi_byte;
                                    param_count_next = param_count_reg + 3'd1;
                                end
                                else if (param_count_reg == 3'd3)
                                begin
                                    param_count_next = 3'd4;
                                    if (opcode_reg == OP_COLUMN_SET)
                                    begin
                                        col_first_next  = win_first;
                                        col_last_next   = (32'(win_last) >= 32'(WIDTH)) ?
                                                          COL_MAX : win_last;
                                        cursor_col_next = win_first;
                                    end
                                    else
                                    begin
                                        row_first_next  = win_first;
                                        row_last_next   = (32'(win_last) >= 32'(HEIGHT)) ?
                                                          ROW_MAX : win_last;
                                        cursor_row_next = win_first;
                                    end
                                end
                            end
                            OP_MEMORY_WRITE:
                            begin
                                if (expect_high_reg)
                                begin
                                    high_byte_next   = spi_byte;
                                    expect_high_next = 1'b0;
                                end
                                else
                                begin
                                    wr_en            = in_panel;
                                    expect_high_next = 1'b1;
                                    changed_next     = 1'b1;
                                    if (col_inc > col_last_reg)
                                    begin
                                        cursor_col_next = col_first_reg;
                                        cursor_row_next = (row_inc > row_last_reg) ?
                                                          row_first_reg : row_inc;
                                    end
                                    else
                                    begin
                                        cursor_col_next = col_inc;
                                    end
                                end
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                end
                ACT_FLUSH_DONE:
                begin
                    changed_next = 1'b0;
                end
                default:
                begin
                end
            endcase
        end
    end

    // flush reports the flag before it is cleared
    assign dirty_out = (action == ACT_FLUSH_DONE) ? changed_reg : changed_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            data_mode_reg   <= 1'b0;
            opcode_reg      <= '0;
            param_count_reg <= '0;
            param_bytes_reg <= '{default: '0};
            expect_high_reg <= 1'b0;
            high_byte_reg   <= '0;
            col_first_reg   <= '0;
            col_last_reg    <= COL_MAX;
            row_first_reg   <= '0;
            row_last_reg    <= ROW_MAX;
            cursor_col_reg  <= '0;
            cursor_row_reg  <= '0;
            changed_reg     <= 1'b1;
        end
        else
        begin
            data_mode_reg   <= data_mode_next;
            opcode_reg      <= opcode_next;
            param_count_reg <= param_count_next;
            param_bytes_reg <= param_bytes_next;
            expect_high_reg <= expect_high_next;
            high_byte_reg   <= high_byte_next;
            col_first_reg   <= col_first_next;
            col_last_reg    <= col_last_next;
            row_first_reg   <= row_first_next;
            row_last_reg    <= row_last_next;
            cursor_col_reg  <= cursor_col_next;
            cursor_row_reg  <= cursor_row_next;
            changed_reg     <= changed_next;
        end
    end

    a_flush_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && action == ACT_FLUSH_DONE) |=> !changed_reg)
        else $error("dirty flag not cleared by flush");

    a_write_sets_dirty: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |=> changed_reg)
        else $error("pixel write did not set dirty flag");

    a_write_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> (32'(wr_addr) < 32'(PIXEL_COUNT)))
        else $error("pixel write outside framebuffer");

endmodule

// ----- design/slw_fb.sv -----
// ----------------------------------------------------------------------------
// slw_fb
// Framebuffer: single-port-write, registered-read pixel memory with a
// clearing sweep after reset.
// ----------------------------------------------------------------------------
module slw_fb #(
    parameter int DEPTH = 76800,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [15:0]       wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [15:0]       rd_data,
    output logic              busy
);
    import slw_pkg::*;

    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);

    logic [PIXEL_W-1:0] mem [DEPTH];
    logic [PIXEL_W-1:0] rd_data_reg;
    logic               busy_reg, busy_next;
    logic [ADDR_W-1:0]  clr_addr_reg, clr_addr_next;
    logic               mem_we;
    logic [ADDR_W-1:0]  mem_addr;
    logic [PIXEL_W-1:0] mem_data;

    assign mem_we   = busy_reg | wr_en;
    assign mem_addr = busy_reg ? clr_addr_reg : wr_addr;
    assign mem_data = busy_reg ? '0 : wr_data;
    assign rd_data  = rd_data_reg;
    assign busy     = busy_reg;

    always_comb
    begin
        busy_next     = busy_reg;
        clr_addr_next = clr_addr_reg;
        if (busy_reg)
        begin
            if (clr_addr_reg == LAST_ADDR)
            begin
                busy_next = 1'b0;
            end
            else
            begin
                clr_addr_next = clr_addr_reg + ADDR_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg     <= 1'b1;
            clr_addr_reg <= '0;
        end
        else
        begin
            busy_reg     <= busy_next;
            clr_addr_reg <= clr_addr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_addr] <= mem_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    a_no_write_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> !busy_reg)
        else $error("pixel write during clearing sweep");

    a_sweep_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg && clr_addr_reg == LAST_ADDR) |=> !busy_reg)
        else $error("clearing sweep did not end at last entry");

    a_sweep_once: assert property (@(posedge clk) disable iff (!rst_n)
        !busy_reg |=> !busy_reg)
        else $error("clearing sweep restarted");

endmodule

// ----- design/spi_lcd_window_pixel_writer_core.sv -----
// ----------------------------------------------------------------------------
// spi_lcd_window_pixel_writer_core
// SPI LCD controller front end with a windowed RGB565 framebuffer.
// ----------------------------------------------------------------------------
// Takes one transaction per cycle while out_ready is high and the framebuffer
// is not being cleared, and returns one result per transaction through an
// input register and a result register. The framebuffer has one write port
// and one registered read port; a pixel write and a pixel read never collide
// since they use separate ports, and every accepted transaction reads. After
// reset the framebuffer is cleared one entry per cycle, all WIDTH*HEIGHT
// entries (76800 at the defaults), with in_ready held low until it is done.
// ----------------------------------------------------------------------------
module spi_lcd_window_pixel_writer_core #(
    parameter int WIDTH = 240,
    parameter int HEIGHT = 320
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  action,
    input  logic        dc_level,
    input  logic [7:0]  spi_byte,
    input  logic [16:0] read_address,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  miso_byte,
    output logic [15:0] pixel_value,
    output logic        dirty
);
    import slw_pkg::*;

    localparam int PIXEL_COUNT = WIDTH * HEIGHT;
    localparam int ADDR_W = (PIXEL_COUNT > 1) ? $clog2(PIXEL_COUNT) : 1;

    logic               s0_valid_reg, s0_valid_next;
    action_t            s0_action_reg;
    logic               s0_dc_reg;
    logic [BYTE_W-1:0]  s0_byte_reg;
    logic [16:0]        s0_addr_reg;
    logic               out_valid_reg, out_valid_next;
    logic               out_dirty_reg;
    logic               out_pix_ok_reg;

    logic               in_fire;
    logic               s1_advance;
    logic               s0_fire;
    logic               pix_ok;
    logic               fb_busy;
    logic               wr_en;
    logic [ADDR_W-1:0]  wr_addr;
    logic [PIXEL_W-1:0] wr_data;
    logic [PIXEL_W-1:0] rd_data;
    logic               dirty_out;

    assign s1_advance = !out_valid_reg || out_ready;
    assign s0_fire    = s0_valid_reg && s1_advance;
    assign in_ready   = !fb_busy && (!s0_valid_reg || s1_advance);
    assign in_fire    = in_valid && in_ready;
    assign pix_ok     = (s0_action_reg == ACT_READ_PIXEL) &&
                        (32'(s0_addr_reg) < 32'(PIXEL_COUNT));

    assign s0_valid_next  = in_fire ? 1'b1 : (s0_fire ? 1'b0 : s0_valid_reg);
    assign out_valid_next = s0_fire ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);

    slw_ctrl #(
        .WIDTH  (WIDTH),
        .HEIGHT (HEIGHT)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (s0_fire),
        .action    (s0_action_reg),
        .dc_level  (s0_dc_reg),
        .spi_byte  (s0_byte_reg),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .dirty_out (dirty_out)
    );

    slw_fb #(
        .DEPTH (PIXEL_COUNT)
    ) u_fb (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (s0_fire),
        .rd_addr (ADDR_W'(s0_addr_reg)),
        .rd_data (rd_data),
        .busy    (fb_busy)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s0_valid_reg  <= s0_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s0_action_reg <= action_t'(action);
            s0_dc_reg     <= dc_level;
            s0_byte_reg   <= spi_byte;
            s0_addr_reg   <= read_address;
        end
        if (s0_fire)
        begin
            out_dirty_reg  <= dirty_out;
            out_pix_ok_reg <= pix_ok;
        end
    end

    assign out_valid   = out_valid_reg;
    assign miso_byte   = '0;
    assign pixel_value = out_pix_ok_reg ? rd_data : '0;
    assign dirty       = out_dirty_reg;

endmodule
